FILE: hdl/mwm_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package mwm_pkg;

  // Field widths
  localparam int CMD_W   = 9;   // drive command
  localparam int OUT_W   = 9;   // wheel power
  localparam int MP_W    = 8;   // min_power register
  localparam int PWR_W   = 11;  // mixed power, |p| <= 768
  localparam int MAG_W   = 10;  // magnitude of a mixed power
  localparam int LANES   = 4;   // FL, FR, BL, BR

  // Dead-band constants
  localparam int OUT_LIMIT = 255;
  localparam logic [MP_W-1:0] MP_RESET = 8'd25;

  // Default full-scale magnitude for the normalize step
  localparam int FULL_SCALE_DEF = 255;

  // Config port
  localparam int APB_AW    = 3;
  localparam int APB_DW    = 32;
  localparam int REG_IDX_W = 1;
  localparam logic [REG_IDX_W-1:0] REG_MIN_POWER = 1'b0;

  // Lane order
  localparam int LANE_FL = 0;
  localparam int LANE_FR = 1;
  localparam int LANE_BL = 2;
  localparam int LANE_BR = 3;

  typedef logic signed [PWR_W-1:0] pwr_t;

  // Per-word control carried down the pipe
  typedef struct packed {
    logic valid;
    logic scale;
  } mix_ctl_t;

endpackage

`default_nettype wire

FILE: hdl/mecanum_wheel_mixer_top.sv
`timescale 1ns / 1ps
`default_nettype none

// Channel   Handshake            Payload
// command   start / busy         strafe_cmd_i, forward_cmd_i, rotate_cmd_i
// result    done_o (one cycle)   front_left_power_o .. back_right_power_o
// config    APB psel/penable     paddr, pwdata, prdata (min_power at 0x0)
//
// A command word is taken in every cycle with start high and busy low;
// the one-bit-per-stage divider that normalizes the four powers sits between
// two mix stages and three dead-band stages.
// busy is high during reset and for the first cycle after it, then stays low.
// Results cannot be held off: done_o marks each word for exactly one cycle.

module mecanum_wheel_mixer_top import mwm_pkg::*; #(
  parameter int FULL_SCALE = FULL_SCALE_DEF
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start,
  output logic                    busy,
  input  logic signed [CMD_W-1:0] strafe_cmd_i,
  input  logic signed [CMD_W-1:0] forward_cmd_i,
  input  logic signed [CMD_W-1:0] rotate_cmd_i,
  output logic                    done_o,
  output logic signed [OUT_W-1:0] front_left_power_o,
  output logic signed [OUT_W-1:0] front_right_power_o,
  output logic signed [OUT_W-1:0] back_left_power_o,
  output logic signed [OUT_W-1:0] back_right_power_o,
  input  logic                    psel,
  input  logic                    penable,
  input  logic                    pwrite,
  input  logic [APB_AW-1:0]       paddr,
  input  logic [APB_DW-1:0]       pwdata,
  output logic [APB_DW-1:0]       prdata,
  output logic                    pready
);

  localparam int QW = $clog2(FULL_SCALE + 1);
  localparam int NW = MAG_W + QW;

  logic                    busy_q;
  logic                    accept;
  logic [MP_W-1:0]         min_power;

  mix_ctl_t                mix_ctl;
  pwr_t                    mix_p   [LANES];
  logic [NW-1:0]           mix_num [LANES];
  logic [MAG_W-1:0]        mix_top;

  logic                    div_valid;
  pwr_t                    div_p [LANES];

  logic signed [OUT_W-1:0] pwr [LANES];

  // Busy only around reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b1;
    end else begin
      busy_q <= 1'b0;
    end
  end

  assign busy   = busy_q;
  assign accept = start && !busy_q;

  mwm_apb u_apb (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready),
    .min_power_o (min_power)
  );

  mwm_mix #(.FULL_SCALE(FULL_SCALE)) u_mix (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .valid_i   (accept),
    .strafe_i  (strafe_cmd_i),
    .forward_i (forward_cmd_i),
    .rotate_i  (rotate_cmd_i),
    .ctl_o     (mix_ctl),
    .p_o       (mix_p),
    .num_o     (mix_num),
    .top_o     (mix_top)
  );

  mwm_div #(.FULL_SCALE(FULL_SCALE)) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctl_i   (mix_ctl),
    .p_i     (mix_p),
    .num_i   (mix_num),
    .top_i   (mix_top),
    .valid_o (div_valid),
    .p_o     (div_p)
  );

  mwm_dband u_dband (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .valid_i     (div_valid),
    .p_i         (div_p),
    .min_power_i (min_power),
    .valid_o     (done_o),
    .pwr_o       (pwr)
  );

  assign front_left_power_o  = pwr[LANE_FL];
  assign front_right_power_o = pwr[LANE_FR];
  assign back_left_power_o   = pwr[LANE_BL];
  assign back_right_power_o  = pwr[LANE_BR];

endmodule

`default_nettype wire

FILE: hdl/mwm_apb.sv
`timescale 1ns / 1ps
`default_nettype none

module mwm_apb import mwm_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready,
  output logic [MP_W-1:0]   min_power_o
);

  logic [MP_W-1:0]      min_power_q, min_power_d;
  logic [REG_IDX_W-1:0] reg_idx;
  logic                 wr_en;

  assign pready  = 1'b1;
  assign reg_idx = paddr[APB_AW-1:2];
  assign wr_en   = psel && penable && pwrite && pready;

  // Register write
  always_comb begin
    min_power_d = min_power_q;
    if (wr_en && (reg_idx == REG_MIN_POWER)) begin
      min_power_d = pwdata[MP_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_power_q <= MP_RESET;
    end else begin
      min_power_q <= min_power_d;
    end
  end

  // Read mux
  always_comb begin
    case (reg_idx)
      REG_MIN_POWER: prdata = APB_DW'(min_power_q);
      default:       prdata = '0;
    endcase
  end

  assign min_power_o = min_power_q;

endmodule

`default_nettype wire

FILE: hdl/mwm_mix.sv
`timescale 1ns / 1ps
`default_nettype none

module mwm_mix import mwm_pkg::*; #(
  parameter  int FULL_SCALE = FULL_SCALE_DEF,
  localparam int QW = $clog2(FULL_SCALE + 1),
  localparam int NW = MAG_W + QW
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    valid_i,
  input  logic signed [CMD_W-1:0] strafe_i,
  input  logic signed [CMD_W-1:0] forward_i,
  input  logic signed [CMD_W-1:0] rotate_i,
  output mix_ctl_t                ctl_o,
  output pwr_t                    p_o   [LANES],
  output logic [NW-1:0]           num_o [LANES],
  output logic [MAG_W-1:0]        top_o
);

  pwr_t              x, y, z;
  pwr_t              mix_d [LANES];
  pwr_t              p1_q  [LANES];
  logic              v1_q;

  logic [MAG_W-1:0]  mag   [LANES];
  logic [MAG_W-1:0]  max01, max23, top_d;
  logic [NW-1:0]     num_d [LANES];

  pwr_t              p2_q   [LANES];
  logic [NW-1:0]     num_q  [LANES];
  logic [MAG_W-1:0]  top_q;
  mix_ctl_t          ctl_q, ctl_d;

  // Stage 1: wheel mix
  always_comb begin
    x = pwr_t'(strafe_i);
    y = pwr_t'(forward_i);
    z = pwr_t'(rotate_i);
    mix_d[LANE_FL] = y + x + z;
    mix_d[LANE_FR] = y - x - z;
    mix_d[LANE_BL] = y - x + z;
    mix_d[LANE_BR] = y + x - z;
  end

  always_ff @(posedge clk_i) begin
    p1_q <= mix_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else begin
      v1_q <= valid_i;
    end
  end

  // Stage 2: magnitudes, largest magnitude, scaled numerators
  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      mag[l]   = p1_q[l][PWR_W-1] ? MAG_W'(-p1_q[l]) : MAG_W'(p1_q[l]);
      num_d[l] = NW'(mag[l]) * NW'(FULL_SCALE);
    end
    max01 = (mag[1] > mag[0]) ? mag[1] : mag[0];
    max23 = (mag[3] > mag[2]) ? mag[3] : mag[2];
    top_d = (max23 > max01) ? max23 : max01;
    ctl_d.valid = v1_q;
    ctl_d.scale = 32'(top_d) > 32'(FULL_SCALE);
  end

  always_ff @(posedge clk_i) begin
    p2_q  <= p1_q;
    num_q <= num_d;
    top_q <= top_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_q <= '0;
    end else begin
      ctl_q <= ctl_d;
    end
  end

  assign ctl_o = ctl_q;
  assign p_o   = p2_q;
  assign num_o = num_q;
  assign top_o = top_q;

endmodule

`default_nettype wire

FILE: hdl/mwm_div.sv
`timescale 1ns / 1ps
`default_nettype none

// Pipelined restoring divider, one quotient bit per stage, four lanes
// sharing one divisor (the largest magnitude).
module mwm_div import mwm_pkg::*; #(
  parameter  int FULL_SCALE = FULL_SCALE_DEF,
  localparam int QW = $clog2(FULL_SCALE + 1),
  localparam int NW = MAG_W + QW
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  mix_ctl_t         ctl_i,
  input  pwr_t             p_i   [LANES],
  input  logic [NW-1:0]    num_i [LANES],
  input  logic [MAG_W-1:0] top_i,
  output logic             valid_o,
  output pwr_t             p_o   [LANES]
);

  logic [NW-1:0]    rem_q [QW][LANES];
  logic [QW-1:0]    quo_q [QW][LANES];
  pwr_t             p_q   [QW][LANES];
  logic [MAG_W-1:0] top_q [QW];
  mix_ctl_t         ctl_q [QW];

  for (genvar i = 0; i < QW; i++) begin : g_stage
    localparam int B = QW - 1 - i;

    logic [NW-1:0]    rem_in [LANES];
    logic [QW-1:0]    quo_in [LANES];
    pwr_t             p_in   [LANES];
    logic [MAG_W-1:0] top_in;
    mix_ctl_t         ctl_in;
    logic [NW-1:0]    dvs;
    logic [NW-1:0]    rem_d  [LANES];
    logic [QW-1:0]    quo_d  [LANES];

    if (i == 0) begin : g_first
      assign rem_in = num_i;
      assign p_in   = p_i;
      assign top_in = top_i;
      assign ctl_in = ctl_i;
      always_comb begin
        for (int l = 0; l < LANES; l++) begin
          quo_in[l] = '0;
        end
      end
    end else begin : g_next
      assign rem_in = rem_q[i-1];
      assign quo_in = quo_q[i-1];
      assign p_in   = p_q[i-1];
      assign top_in = top_q[i-1];
      assign ctl_in = ctl_q[i-1];
    end

    // Trial subtract of divisor shifted to this bit
    always_comb begin
      dvs = NW'(top_in) << B;
      for (int l = 0; l < LANES; l++) begin
        rem_d[l] = rem_in[l];
        quo_d[l] = quo_in[l];
        if (rem_in[l] >= dvs) begin
          rem_d[l] = rem_in[l] - dvs;
          quo_d[l] = quo_in[l] | (QW'(1) << B);
        end
      end
    end

    always_ff @(posedge clk_i) begin
      rem_q[i] <= rem_d;
      quo_q[i] <= quo_d;
      p_q[i]   <= p_in;
      top_q[i] <= top_in;
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        ctl_q[i] <= '0;
      end else begin
        ctl_q[i] <= ctl_in;
      end
    end
  end

  // Reapply sign; quotient magnitude stays below 768 when scaling
  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      pwr_t qs;
      qs = pwr_t'(signed'({1'b0, MAG_W'(quo_q[QW-1][l])}));
      if (ctl_q[QW-1].scale) begin
        p_o[l] = p_q[QW-1][l][PWR_W-1] ? -qs : qs;
      end else begin
        p_o[l] = p_q[QW-1][l];
      end
    end
  end

  assign valid_o = ctl_q[QW-1].valid;

endmodule

`default_nettype wire

FILE: hdl/mwm_dband.sv
`timescale 1ns / 1ps
`default_nettype none

// Dead-band remap, three stages: product, reciprocal estimate of /255,
// correction plus offset and clamp.
module mwm_dband import mwm_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    valid_i,
  input  pwr_t                    p_i [LANES],
  input  logic [MP_W-1:0]         min_power_i,
  output logic                    valid_o,
  output logic signed [OUT_W-1:0] pwr_o [LANES]
);

  localparam int PROD_W = MAG_W + MP_W;    // |base| * span
  localparam int P257_W = PROD_W + 9;      // m * 257
  localparam int RES_W  = PWR_W + 1;
  localparam int SHIFT  = 16;

  // Stage A
  pwr_t              base  [LANES];
  logic [MAG_W-1:0]  bmag  [LANES];
  logic [MP_W-1:0]   span;
  logic [PROD_W-1:0] m_d   [LANES];

  logic [PROD_W-1:0] ma_q    [LANES];
  logic              pnega_q [LANES];
  logic              nega_q  [LANES];
  logic              zeroa_q [LANES];
  logic [MP_W-1:0]   mpa_q;
  logic              va_q;

  always_comb begin
    span = MP_W'(OUT_LIMIT) - min_power_i;
    for (int l = 0; l < LANES; l++) begin
      base[l] = p_i[l][PWR_W-1] ? p_i[l] + pwr_t'(OUT_LIMIT) : p_i[l];
      bmag[l] = base[l][PWR_W-1] ? MAG_W'(-base[l]) : MAG_W'(base[l]);
      m_d[l]  = PROD_W'(bmag[l]) * PROD_W'(span);
    end
  end

  always_ff @(posedge clk_i) begin
    for (int l = 0; l < LANES; l++) begin
      ma_q[l]    <= m_d[l];
      pnega_q[l] <= base[l][PWR_W-1];
      nega_q[l]  <= p_i[l][PWR_W-1];
      zeroa_q[l] <= (p_i[l] == '0);
    end
    mpa_q <= min_power_i;
  end

  // Stage B: est = m*257 >> 16, at most one below m/255
  logic [P257_W-1:0] p257  [LANES];
  logic [MAG_W-1:0]  estb_q  [LANES];
  logic [PROD_W-1:0] mb_q    [LANES];
  logic              pnegb_q [LANES];
  logic              negb_q  [LANES];
  logic              zerob_q [LANES];
  logic [MP_W-1:0]   mpb_q;
  logic              vb_q;

  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      p257[l] = (P257_W'(ma_q[l]) << 8) + P257_W'(ma_q[l]);
    end
  end

  always_ff @(posedge clk_i) begin
    for (int l = 0; l < LANES; l++) begin
      estb_q[l]  <= MAG_W'(p257[l] >> SHIFT);
      mb_q[l]    <= ma_q[l];
      pnegb_q[l] <= pnega_q[l];
      negb_q[l]  <= nega_q[l];
      zerob_q[l] <= zeroa_q[l];
    end
    mpb_q <= mpa_q;
  end

  // Stage C: correction, sign, offset, clamp
  logic [PROD_W-1:0]       est255 [LANES];
  logic [PROD_W-1:0]       rem    [LANES];
  logic [MAG_W-1:0]        quo    [LANES];
  logic signed [RES_W-1:0] qs     [LANES];
  logic signed [RES_W-1:0] res    [LANES];
  logic signed [OUT_W-1:0] pwr_d  [LANES];
  logic signed [OUT_W-1:0] pwr_q  [LANES];
  logic                    vc_q;

  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      est255[l] = (PROD_W'(estb_q[l]) << 8) - PROD_W'(estb_q[l]);
      rem[l]    = mb_q[l] - est255[l];
      quo[l]    = (rem[l] >= PROD_W'(OUT_LIMIT)) ? estb_q[l] + MAG_W'(1) : estb_q[l];
      qs[l]     = signed'(RES_W'(quo[l]));
      if (pnegb_q[l]) begin
        qs[l] = -qs[l];
      end
      if (negb_q[l]) begin
        res[l] = qs[l] - RES_W'(OUT_LIMIT);
      end else begin
        res[l] = qs[l] + signed'(RES_W'(mpb_q));
      end
      if (zerob_q[l]) begin
        pwr_d[l] = '0;
      end else if (res[l] > RES_W'(OUT_LIMIT)) begin
        pwr_d[l] = OUT_W'(OUT_LIMIT);
      end else if (res[l] < -signed'(RES_W'(OUT_LIMIT))) begin
        pwr_d[l] = -signed'(OUT_W'(OUT_LIMIT));
      end else begin
        pwr_d[l] = OUT_W'(res[l]);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    pwr_q <= pwr_d;
  end

  // Valid chain
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
      vb_q <= 1'b0;
      vc_q <= 1'b0;
    end else begin
      va_q <= valid_i;
      vb_q <= va_q;
      vc_q <= vb_q;
    end
  end

  assign valid_o = vc_q;
  assign pwr_o   = pwr_q;

endmodule

`default_nettype wire

FILE: hdl/mwm_chk.sv
`timescale 1ns / 1ps
`default_nettype none

module mwm_chk import mwm_pkg::*; #(
  parameter int FULL_SCALE = FULL_SCALE_DEF
) (
  input logic                    clk_i,
  input logic                    rst_ni,
  input logic                    start,
  input logic                    busy,
  input logic signed [CMD_W-1:0] strafe_cmd_i,
  input logic signed [CMD_W-1:0] forward_cmd_i,
  input logic signed [CMD_W-1:0] rotate_cmd_i,
  input logic                    done_o,
  input logic signed [OUT_W-1:0] front_left_power_o,
  input logic signed [OUT_W-1:0] front_right_power_o,
  input logic signed [OUT_W-1:0] back_left_power_o,
  input logic signed [OUT_W-1:0] back_right_power_o,
  input logic                    pready
);

  localparam int LAT = $clog2(FULL_SCALE + 1) + 5;
  localparam logic [OUT_W-1:0] NEG_FULL = {1'b1, {(OUT_W-1){1'b0}}};

  logic acc;
  logic zero_cmd;

  assign acc      = start && !busy;
  assign zero_cmd = (strafe_cmd_i == '0) && (forward_cmd_i == '0) && (rotate_cmd_i == '0);

  // One result word per accepted command, fixed latency
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o == $past(acc, LAT))
    else $error("result strobe does not match accepted commands");

  // Powers stay within +/-255
  a_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (front_left_power_o != NEG_FULL) && (front_right_power_o != NEG_FULL) &&
               (back_left_power_o != NEG_FULL) && (back_right_power_o != NEG_FULL))
    else $error("wheel power out of range");

  // A stop command gives four zero powers
  a_stop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $past(acc && zero_cmd, LAT) |->
      (front_left_power_o == '0) && (front_right_power_o == '0) &&
      (back_left_power_o == '0) && (back_right_power_o == '0))
    else $error("stop command did not give zero powers");

  // Config port never waits
  a_pready: assert property (@(posedge clk_i) disable iff (!rst_ni) pready)
    else $error("pready low");

endmodule

bind mecanum_wheel_mixer_top mwm_chk #(.FULL_SCALE(FULL_SCALE)) u_chk (.*);

`default_nettype wire

FILE: dv/mecanum_wheel_mixer_top_tb.sv
`timescale 1ns / 1ps

module mecanum_wheel_mixer_top_tb;
  import mwm_pkg::*;

  localparam int NORM_LIMIT  = FULL_SCALE_DEF;
  localparam int CYCLE_LIMIT = 200000;
  localparam int SEG_ITEMS   = 250;
  localparam int N_SEGS      = 6;
  localparam int N_DIR       = 23;
  localparam int DRAIN_WAIT  = 20;

  localparam logic [APB_AW-1:0] MP_ADDR    = APB_AW'(REG_MIN_POWER) << 2;
  localparam logic [APB_AW-1:0] SPARE_ADDR = MP_ADDR + APB_AW'(4);  // no register there

  // 9-bit corner patterns
  localparam logic [CMD_W-1:0] POS_FS  = 9'd255;
  localparam logic [CMD_W-1:0] NEG_FS  = 9'h101;  // -255
  localparam logic [CMD_W-1:0] NEG_MAX = 9'h100;  // -256, outside stated range
  localparam logic [CMD_W-1:0] NEG_ONE = 9'h1FF;

  typedef struct packed {
    logic [OUT_W-1:0] fl;
    logic [OUT_W-1:0] fr;
    logic [OUT_W-1:0] bl;
    logic [OUT_W-1:0] br;
  } wheel_t;

  typedef struct packed {
    logic [CMD_W-1:0] x;
    logic [CMD_W-1:0] y;
    logic [CMD_W-1:0] z;
    logic             has_want;
    wheel_t           want;
  } dir_row_t;

  // Directed commands at reset min_power (25); typed powers where obvious
  dir_row_t dir_tbl [N_DIR] = '{
    '{9'd0,    9'd0,    9'd0,    1'b1, '{9'd0,   9'd0,   9'd0,   9'd0}},
    '{9'd0,    POS_FS,  9'd0,    1'b1, '{POS_FS, POS_FS, POS_FS, POS_FS}},
    '{9'd0,    NEG_FS,  9'd0,    1'b1, '{NEG_FS, NEG_FS, NEG_FS, NEG_FS}},
    '{POS_FS,  9'd0,    9'd0,    1'b1, '{POS_FS, NEG_FS, NEG_FS, POS_FS}},
    '{NEG_FS,  9'd0,    9'd0,    1'b1, '{NEG_FS, POS_FS, POS_FS, NEG_FS}},
    '{9'd0,    9'd0,    POS_FS,  1'b1, '{POS_FS, NEG_FS, POS_FS, NEG_FS}},
    '{9'd0,    9'd0,    NEG_FS,  1'b1, '{NEG_FS, POS_FS, NEG_FS, POS_FS}},
    '{9'd0,    9'd1,    9'd0,    1'b1, '{9'd25,  9'd25,  9'd25,  9'd25}},
    '{9'd0,    NEG_ONE, 9'd0,    1'b0, '0},
    '{POS_FS,  POS_FS,  POS_FS,  1'b0, '0},
    '{NEG_FS,  NEG_FS,  NEG_FS,  1'b0, '0},
    '{NEG_MAX, 9'd0,    9'd0,    1'b0, '0},
    '{9'd0,    NEG_MAX, 9'd0,    1'b0, '0},
    '{9'd0,    9'd0,    NEG_MAX, 1'b0, '0},
    '{NEG_MAX, NEG_MAX, NEG_MAX, 1'b0, '0},
    '{POS_FS,  NEG_MAX, POS_FS,  1'b0, '0},
    '{9'd1,    9'd0,    9'd0,    1'b0, '0},
    '{9'd0,    9'd0,    NEG_ONE, 1'b0, '0},
    '{9'd1,    9'd1,    9'd1,    1'b0, '0},
    '{9'd100,  9'h1CE,  9'd30,   1'b0, '0},
    '{9'h180,  9'd127,  9'h1C0,  1'b0, '0},
    '{POS_FS,  POS_FS,  9'd0,    1'b0, '0},
    '{9'd0,    9'd128,  9'd127,  1'b0, '0}
  };

  logic                    clk_i = 1'b0;
  logic                    rst_ni = 1'b0;
  logic                    start = 1'b0;
  logic                    busy;
  logic signed [CMD_W-1:0] strafe_cmd = '0;
  logic signed [CMD_W-1:0] forward_cmd = '0;
  logic signed [CMD_W-1:0] rotate_cmd = '0;
  logic                    done_o;
  logic signed [OUT_W-1:0] fl_pwr, fr_pwr, bl_pwr, br_pwr;
  logic                    psel = 1'b0;
  logic                    penable = 1'b0;
  logic                    pwrite = 1'b0;
  logic [APB_AW-1:0]       paddr = '0;
  logic [APB_DW-1:0]       pwdata = '0;
  logic [APB_DW-1:0]       prdata;
  logic                    pready;

  // Predictor state
  logic [MP_W-1:0] min_power_q = MP_RESET;
  wheel_t          wheel_q [$];
  wheel_t          mon_want;

  int err_cnt       = 0;
  int words_sent    = 0;
  int words_checked = 0;
  int cycle_cnt     = 0;
  int mp_settings   = 1;

  always #5 clk_i = ~clk_i;

  mecanum_wheel_mixer_top dut (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .start               (start),
    .busy                (busy),
    .strafe_cmd_i        (strafe_cmd),
    .forward_cmd_i       (forward_cmd),
    .rotate_cmd_i        (rotate_cmd),
    .done_o              (done_o),
    .front_left_power_o  (fl_pwr),
    .front_right_power_o (fr_pwr),
    .back_left_power_o   (bl_pwr),
    .back_right_power_o  (br_pwr),
    .psel                (psel),
    .penable             (penable),
    .pwrite              (pwrite),
    .paddr               (paddr),
    .pwdata              (pwdata),
    .prdata              (prdata),
    .pready              (pready)
  );

  // Mix, normalize to full scale, then push each nonzero power past the dead band
  function automatic wheel_t mix_wheels(input logic signed [CMD_W-1:0] xs,
                                        input logic signed [CMD_W-1:0] ys,
                                        input logic signed [CMD_W-1:0] zs,
                                        input logic [MP_W-1:0] mp_bits);
    int x, y, z, mp, top, span, r;
    int p [LANES];
    wheel_t w;
    x = xs;
    y = ys;
    z = zs;
    mp = mp_bits;
    span = OUT_LIMIT - mp;
    p[LANE_FL] = y + x + z;
    p[LANE_FR] = y - x - z;
    p[LANE_BL] = y - x + z;
    p[LANE_BR] = y + x - z;
    top = 0;
    for (int i = 0; i < LANES; i++) begin
      if ((p[i] < 0 ? -p[i] : p[i]) > top) top = p[i] < 0 ? -p[i] : p[i];
    end
    for (int i = 0; i < LANES; i++) begin
      if (top > NORM_LIMIT) p[i] = (p[i] * NORM_LIMIT) / top;
      if (p[i] < 0) r = ((p[i] + OUT_LIMIT) * span) / OUT_LIMIT - OUT_LIMIT;
      else if (p[i] > 0) r = (p[i] * span) / OUT_LIMIT + mp;
      else r = 0;
      if (r > OUT_LIMIT) r = OUT_LIMIT;
      if (r < -OUT_LIMIT) r = -OUT_LIMIT;
      p[i] = r;
    end
    w.fl = p[LANE_FL][OUT_W-1:0];
    w.fr = p[LANE_FR][OUT_W-1:0];
    w.bl = p[LANE_BL][OUT_W-1:0];
    w.br = p[LANE_BR][OUT_W-1:0];
    return w;
  endfunction

  // Random command value: corners, values near zero, or anything in 9 bits
  function automatic logic [CMD_W-1:0] rand_cmd();
    int mode;
    int v;
    mode = $urandom_range(0, 99);
    if (mode < 15) begin
      case ($urandom_range(0, 5))
        0: return NEG_MAX;
        1: return NEG_FS;
        2: return NEG_ONE;
        3: return '0;
        4: return 9'd1;
        default: return POS_FS;
      endcase
    end else if (mode < 35) begin
      v = $urandom_range(0, 8);
      v = v - 4;
      return v[CMD_W-1:0];
    end
    return CMD_W'($urandom_range(0, 511));
  endfunction

  task automatic report_mismatch(input string msg);
    if (err_cnt < 50) $display("MISMATCH @%0t: %s", $time, msg);
    err_cnt++;
  endtask

  task automatic compare_lane(input string lane, input logic [OUT_W-1:0] got,
                              input logic [OUT_W-1:0] want);
    if (got !== want)
      report_mismatch($sformatf("%s power got %0d want %0d", lane, $signed(got),
                                $signed(want)));
  endtask

  // APB transfer: setup cycle, access until pready, then back to idle
  task automatic apb_xfer(input logic wr, input logic [APB_AW-1:0] addr,
                          input logic [APB_DW-1:0] wdata, output logic [APB_DW-1:0] rdata);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= addr;
    pwdata  <= wdata;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    rdata = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic set_min_power(input logic [MP_W-1:0] mp);
    logic [APB_DW-1:0] rd;
    apb_xfer(1'b1, MP_ADDR, APB_DW'(mp), rd);
    min_power_q = mp;
    mp_settings++;
    apb_xfer(1'b0, MP_ADDR, '0, rd);
    if (rd !== APB_DW'(min_power_q))
      report_mismatch($sformatf("min_power read back %0h want %0h", rd, min_power_q));
  endtask

  // One command word; returns after the accepting edge
  task automatic send_cmd(input logic [CMD_W-1:0] x, input logic [CMD_W-1:0] y,
                          input logic [CMD_W-1:0] z, input logic use_want,
                          input wheel_t want);
    start       <= 1'b1;
    strafe_cmd  <= x;
    forward_cmd <= y;
    rotate_cmd  <= z;
    do @(posedge clk_i); while (busy);
    wheel_q.insert(wheel_q.size(), use_want ? want : mix_wheels(x, y, z, min_power_q));
    words_sent++;
  endtask

  task automatic wait_drained();
    while (wheel_q.size() != 0) @(posedge clk_i);
  endtask

  // Result checker: every done_o word against the oldest prediction
  always @(posedge clk_i) begin
    if (rst_ni && done_o) begin
      if (wheel_q.size() == 0) begin
        report_mismatch("result word with no command pending");
      end else begin
        mon_want = wheel_q.pop_front();
        compare_lane("front_left", fl_pwr, mon_want.fl);
        compare_lane("front_right", fr_pwr, mon_want.fr);
        compare_lane("back_left", bl_pwr, mon_want.bl);
        compare_lane("back_right", br_pwr, mon_want.br);
        words_checked++;
      end
    end
  end

  // Run watchdog
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  initial begin
    logic [MP_W-1:0] mp_list [N_SEGS];
    logic [APB_DW-1:0] rd;
    int idle_pct;
    mp_list = '{8'd0, 8'd255, 8'd0, 8'd1, 8'd254, 8'd0};
    mp_list[2] = MP_W'($urandom_range(2, 253));
    mp_list[5] = MP_W'($urandom_range(0, 255));

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed part, back to back at the reset min_power
    for (int i = 0; i < N_DIR; i++)
      send_cmd(dir_tbl[i].x, dir_tbl[i].y, dir_tbl[i].z, dir_tbl[i].has_want,
               dir_tbl[i].want);
    start <= 1'b0;
    wait_drained();

    // Random segments: sender idles in 28% of cycles, then 56%, then never
    for (int seg = 0; seg < N_SEGS; seg++) begin
      idle_pct = (seg < 2) ? 28 : (seg < 4) ? 56 : 0;
      set_min_power(mp_list[seg]);
      // a write to an unmapped index must leave min_power alone
      if (seg == 3) apb_xfer(1'b1, SPARE_ADDR, $urandom, rd);
      for (int n = 0; n < SEG_ITEMS; n++) begin
        send_cmd(rand_cmd(), rand_cmd(), rand_cmd(), 1'b0, '0);
        while ($urandom_range(0, 99) < idle_pct) begin
          start <= 1'b0;
          @(posedge clk_i);
        end
      end
      start <= 1'b0;
      wait_drained();
    end

    repeat (DRAIN_WAIT) @(posedge clk_i);
    if (wheel_q.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", wheel_q.size()));

    $display("Ran %0d drive commands (%0d directed) across %0d min_power settings,",
             words_sent, N_DIR, mp_settings);
    $display("checked %0d wheel power words, %0d mismatches", words_checked, err_cnt);
    if (err_cnt == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
